>>> design/hemef_pkg.sv
`default_nettype none
package hemef_pkg;
	localparam int unsigned ValW = 16;
	localparam logic [ValW-1:0] NIL = 16'hFFFF;

	typedef enum logic [1:0] {
		CMD_WRITE = 2'd0,
		CMD_READ  = 2'd1,
		CMD_FLIP  = 2'd2,
		CMD_BAD   = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		TBL_HV  = 3'd0,
		TBL_HO  = 3'd1,
		TBL_EH  = 3'd2,
		TBL_HE  = 3'd3,
		TBL_VO  = 3'd4
	} tbl_t;

	// One memory access request from the sequencer.
	typedef struct packed {
		logic            we;
		logic            re;
		logic [ValW-1:0] addr;
		logic [ValW-1:0] wdata;
	} mem_req_t;
endpackage
`default_nettype wire

>>> design/half_edge_mesh_edge_flip.sv
`default_nettype none
// Half-edge triangle mesh store with edge flip.
//
// The host issues one item at a time on start while busy is low. Each item
// carries a command (write entry, read entry, flip edge), a table selector,
// an entry index and a write value. Exactly one result comes back for every
// item, shown on read_value, flip_done and status while done is high for a
// single cycle; the receiver cannot stall, so it must take it then.
//
// Reads and writes of single entries pass through an access step, a wait step
// and the done step, and the next item can be taken at the edge that ends the
// done cycle; an unknown command goes straight to the done step. A flip is
// done by a sequencer that runs all accesses through five single-port
// synchronous RAMs, one access per RAM per step. A boundary edge, and a
// malformed flip at the check that trips, end the flip early. The length of
// a full flip is set by the chain of dependent reads (edge to half-edge to
// opposite, then vertices, side edges, side opposites and outgoing
// half-edges) and by the write-back order, which must reproduce the exact
// overwrite order of shared entries.
//
// Reset clears only control state. The tables hold unknown values until the
// host writes them; there is no clearing pass.
module half_edge_mesh_edge_flip
	import hemef_pkg::*;
#(
	parameter int HALF_EDGE_DEPTH = 4096,
	parameter int VERTEX_DEPTH = 4096,
	parameter int EDGE_DEPTH = 4096
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         start,
	output logic        busy,
	input  wire  [1:0]  command,
	input  wire  [2:0]  table_select,
	input  wire  [11:0] entry_index,
	input  wire  [15:0] write_value,
	output logic        done,
	output logic [15:0] read_value,
	output logic        flip_done,
	output logic        status
);
	localparam int HW = $clog2(HALF_EDGE_DEPTH);
	localparam int VW = $clog2(VERTEX_DEPTH);
	localparam int EW = $clog2(EDGE_DEPTH);
	localparam logic [16:0] HD = 17'(HALF_EDGE_DEPTH);
	localparam logic [16:0] VD = 17'(VERTEX_DEPTH);
	localparam logic [16:0] ED = 17'(EDGE_DEPTH);

	// Microcode step numbers of the flip sequencer.
	typedef enum logic [6:0] {
		S_IDLE, S_SACC, S_SWAIT,
		F_EH, F_EHW, F_HO, F_HOW, F_RD0, F_RD1, F_RD2, F_RD3, F_RD4, F_CHK,
		F_W0, F_W1, F_W2, F_W3, F_W4, F_W5,
		F_O0, F_O1, F_O2, F_O3, F_O4, F_O5, F_O6, F_O7,
		F_E0, F_E1, F_E2, F_E3,
		F_P0, F_P0W, F_P0X, F_P1, F_P1W, F_P1X, F_P2, F_P2W, F_P2X,
		F_P3, F_P3W, F_P3X,
		F_V0, F_V0W, F_V1, F_V1W, F_V2, F_V2W, F_V3, F_V3W,
		S_DONE
	} state_t;

	state_t state_q;
	logic [1:0]  cmd_q;
	logic [2:0]  sel_q;
	logic [11:0] idx_q;
	logic [15:0] val_q;
	logic [15:0] ha_q, hb_q, pa_q, na_q, pb_q, nb_q;
	logic [15:0] va_q, vb_q, vc_q, vd_q;
	logic [15:0] et_q [4];
	logic [15:0] ot_q [4];
	logic [15:0] tmp_q;
	logic        bad_q;

	mem_req_t hv_r, ho_r, eh_r, he_r, vo_r;
	logic [15:0] hv_d, ho_d, eh_d, he_d, vo_d;

	hemef_ram #(.Width(16), .Depth(HALF_EDGE_DEPTH)) u_hv (
		.clk, .we(hv_r.we), .addr(hv_r.addr[HW-1:0]), .wdata(hv_r.wdata), .rdata(hv_d));
	hemef_ram #(.Width(16), .Depth(HALF_EDGE_DEPTH)) u_ho (
		.clk, .we(ho_r.we), .addr(ho_r.addr[HW-1:0]), .wdata(ho_r.wdata), .rdata(ho_d));
	hemef_ram #(.Width(16), .Depth(EDGE_DEPTH)) u_eh (
		.clk, .we(eh_r.we), .addr(eh_r.addr[EW-1:0]), .wdata(eh_r.wdata), .rdata(eh_d));
	hemef_ram #(.Width(16), .Depth(HALF_EDGE_DEPTH)) u_he (
		.clk, .we(he_r.we), .addr(he_r.addr[HW-1:0]), .wdata(he_r.wdata), .rdata(he_d));
	hemef_ram #(.Width(16), .Depth(VERTEX_DEPTH)) u_vo (
		.clk, .we(vo_r.we), .addr(vo_r.addr[VW-1:0]), .wdata(vo_r.wdata), .rdata(vo_d));

	// Triangle helpers on a half-edge below 65535; mod 3 by a reciprocal.
	function automatic logic [16:0] tri_base(input logic [15:0] h);
		logic [33:0] p;
		logic [16:0] q;
		begin
			p = 34'(h) * 34'd43691;
			q = 17'(p[33:17]);
			tri_base = 17'(q * 17'd3);
		end
	endfunction

	function automatic logic tri_fits(input logic [15:0] h);
		tri_fits = (17'(h) < HD) && (tri_base(h) + 17'd2 < HD);
	endfunction

	function automatic logic opp_ok(input logic [15:0] o);
		opp_ok = (o == NIL) || (17'(o) < HD);
	endfunction

	// Single entry access: decode the table and check the range.
	logic sel_ok;
	always_comb begin
		unique case (sel_q)
			TBL_HV, TBL_HO, TBL_HE: sel_ok = 17'(idx_q) < HD;
			TBL_EH:                 sel_ok = 17'(idx_q) < ED;
			TBL_VO:                 sel_ok = 17'(idx_q) < VD;
			default:                sel_ok = 1'b0;
		endcase
	end

	logic [16:0] hb_base;
	logic [16:0] ha_base;
	always_comb begin
		ha_base = tri_base(ha_q);
		hb_base = tri_base(hb_q);
	end

	// Memory requests by step. The side half-edges are known from RD1 on, so
	// their edge and opposite reads start at RD1, after the first vertex read.
	always_comb begin
		hv_r = '0; ho_r = '0; eh_r = '0; he_r = '0; vo_r = '0;
		unique case (state_q)
			S_SACC: begin
				if (sel_ok) begin
					case (sel_q)
						TBL_HV: hv_r = '{cmd_q == CMD_WRITE, 1'b1, 16'(idx_q), val_q};
						TBL_HO: ho_r = '{cmd_q == CMD_WRITE, 1'b1, 16'(idx_q), val_q};
						TBL_EH: eh_r = '{cmd_q == CMD_WRITE, 1'b1, 16'(idx_q), val_q};
						TBL_HE: he_r = '{cmd_q == CMD_WRITE, 1'b1, 16'(idx_q), val_q};
						default: vo_r = '{cmd_q == CMD_WRITE, 1'b1, 16'(idx_q), val_q};
					endcase
				end
			end
			F_EH: eh_r = '{1'b0, 1'b1, 16'(idx_q), '0};
			F_HO: ho_r = '{1'b0, 1'b1, ha_q, '0};
			F_RD0: begin
				hv_r.addr = ha_q;
			end
			F_RD1: begin
				hv_r.addr = hb_q; he_r.addr = pa_q; ho_r.addr = pa_q;
			end
			F_RD2: begin
				hv_r.addr = pa_q; he_r.addr = na_q; ho_r.addr = na_q;
			end
			F_RD3: begin
				hv_r.addr = pb_q; he_r.addr = pb_q; ho_r.addr = pb_q;
			end
			F_RD4: begin
				he_r.addr = nb_q; ho_r.addr = nb_q;
			end
			F_W0: hv_r = '{1'b1, 1'b0, pa_q, vb_q};
			F_W1: hv_r = '{1'b1, 1'b0, ha_q, vc_q};
			F_W2: hv_r = '{1'b1, 1'b0, na_q, vd_q};
			F_W3: hv_r = '{1'b1, 1'b0, pb_q, va_q};
			F_W4: hv_r = '{1'b1, 1'b0, hb_q, vd_q};
			F_W5: hv_r = '{1'b1, 1'b0, nb_q, vc_q};
			F_O0: ho_r = '{ot_q[0] != NIL, 1'b0, ot_q[0], nb_q};
			F_O1: ho_r = '{ot_q[1] != NIL, 1'b0, ot_q[1], pa_q};
			F_O2: ho_r = '{ot_q[2] != NIL, 1'b0, ot_q[2], na_q};
			F_O3: ho_r = '{ot_q[3] != NIL, 1'b0, ot_q[3], pb_q};
			F_O4: ho_r = '{1'b1, 1'b0, pa_q, ot_q[1]};
			F_O5: ho_r = '{1'b1, 1'b0, na_q, ot_q[2]};
			F_O6: ho_r = '{1'b1, 1'b0, pb_q, ot_q[3]};
			F_O7: ho_r = '{1'b1, 1'b0, nb_q, ot_q[0]};
			F_E0: eh_r = '{1'b1, 1'b0, et_q[0], pa_q};
			F_E1: eh_r = '{1'b1, 1'b0, et_q[1], na_q};
			F_E2: eh_r = '{1'b1, 1'b0, et_q[2], pb_q};
			F_E3: eh_r = '{1'b1, 1'b0, et_q[3], nb_q};
			F_P0: begin
				he_r = '{1'b1, 1'b0, pa_q, et_q[0]}; ho_r.addr = pa_q;
			end
			F_P1: begin
				he_r = '{1'b1, 1'b0, na_q, et_q[1]}; ho_r.addr = na_q;
			end
			F_P2: begin
				he_r = '{1'b1, 1'b0, pb_q, et_q[2]}; ho_r.addr = pb_q;
			end
			F_P3: begin
				he_r = '{1'b1, 1'b0, nb_q, et_q[3]}; ho_r.addr = nb_q;
			end
			F_P0X: he_r = '{17'(tmp_q) < HD, 1'b0, tmp_q, et_q[0]};
			F_P1X: he_r = '{17'(tmp_q) < HD, 1'b0, tmp_q, et_q[1]};
			F_P2X: he_r = '{17'(tmp_q) < HD, 1'b0, tmp_q, et_q[2]};
			F_P3X: he_r = '{17'(tmp_q) < HD, 1'b0, tmp_q, et_q[3]};
			F_V0: vo_r.addr = va_q;
			F_V0W: vo_r = '{(vo_d == nb_q) || (vo_d == ha_q), 1'b0, va_q, pb_q};
			F_V1: vo_r.addr = vb_q;
			F_V1W: vo_r = '{(vo_d == na_q) || (vo_d == hb_q), 1'b0, vb_q, pa_q};
			F_V2: vo_r.addr = vc_q;
			F_V2W: vo_r = '{vo_d == pa_q, 1'b0, vc_q, nb_q};
			F_V3: vo_r.addr = vd_q;
			F_V3W: vo_r = '{vo_d == pb_q, 1'b0, vd_q, na_q};
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done <= 1'b0;
			busy <= 1'b0;
			read_value <= '0;
			flip_done <= 1'b0;
			status <= 1'b0;
		end else begin
			done <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						busy <= 1'b1;
						cmd_q <= command; sel_q <= table_select;
						idx_q <= entry_index; val_q <= write_value;
						read_value <= '0; flip_done <= 1'b0; status <= 1'b0;
						if (command == CMD_FLIP) state_q <= F_EH;
						else if (command == CMD_BAD) begin
							status <= 1'b1; state_q <= S_DONE;
						end else state_q <= S_SACC;
					end
				end
				S_SACC: begin
					bad_q <= !sel_ok;
					state_q <= S_SWAIT;
				end
				S_SWAIT: begin
					if (bad_q) status <= 1'b1;
					else if (cmd_q == CMD_READ) begin
						case (sel_q)
							TBL_HV: read_value <= hv_d;
							TBL_HO: read_value <= ho_d;
							TBL_EH: read_value <= eh_d;
							TBL_HE: read_value <= he_d;
							default: read_value <= vo_d;
						endcase
					end
					state_q <= S_DONE;
				end
				F_EH: begin
					if (17'(idx_q) >= ED) begin
						status <= 1'b1; state_q <= S_DONE;
					end else state_q <= F_EHW;
				end
				F_EHW: begin
					ha_q <= eh_d;
					if (!tri_fits(eh_d)) begin
						status <= 1'b1; state_q <= S_DONE;
					end else state_q <= F_HO;
				end
				F_HO: state_q <= F_HOW;
				F_HOW: begin
					hb_q <= ho_d;
					if (ho_d == NIL) state_q <= S_DONE;
					else if (!tri_fits(ho_d)) begin
						status <= 1'b1; state_q <= S_DONE;
					end else state_q <= F_RD0;
				end
				F_RD0: begin
					pa_q <= 16'(ha_base + ((17'(ha_q) - ha_base == 17'd0) ? 17'd2 :
						17'(ha_q) - ha_base - 17'd1));
					na_q <= 16'(ha_base + ((17'(ha_q) - ha_base == 17'd2) ? 17'd0 :
						17'(ha_q) - ha_base + 17'd1));
					pb_q <= 16'(hb_base + ((17'(hb_q) - hb_base == 17'd0) ? 17'd2 :
						17'(hb_q) - hb_base - 17'd1));
					nb_q <= 16'(hb_base + ((17'(hb_q) - hb_base == 17'd2) ? 17'd0 :
						17'(hb_q) - hb_base + 17'd1));
					state_q <= F_RD1;
				end
				F_RD1: begin
					va_q <= hv_d; state_q <= F_RD2;
				end
				F_RD2: begin
					vb_q <= hv_d; et_q[0] <= he_d; ot_q[0] <= ho_d; state_q <= F_RD3;
				end
				F_RD3: begin
					vc_q <= hv_d; et_q[1] <= he_d; ot_q[1] <= ho_d; state_q <= F_RD4;
				end
				F_RD4: begin
					vd_q <= hv_d; et_q[2] <= he_d; ot_q[2] <= ho_d; state_q <= F_CHK;
				end
				F_CHK: begin
					et_q[3] <= he_d; ot_q[3] <= ho_d;
					if (17'(va_q) >= VD || 17'(vb_q) >= VD || 17'(vc_q) >= VD ||
						17'(vd_q) >= VD || 17'(et_q[0]) >= ED || 17'(et_q[1]) >= ED ||
						17'(et_q[2]) >= ED || 17'(he_d) >= ED || !opp_ok(ot_q[0]) ||
						!opp_ok(ot_q[1]) || !opp_ok(ot_q[2]) || !opp_ok(ho_d)) begin
						status <= 1'b1; state_q <= S_DONE;
					end else state_q <= F_W0;
				end
				F_P0W, F_P1W, F_P2W, F_P3W: begin
					tmp_q <= ho_d; state_q <= state_t'(state_q + 7'd1);
				end
				F_V3W: begin
					flip_done <= 1'b1; state_q <= S_DONE;
				end
				S_DONE: begin
					done <= 1'b1; busy <= 1'b0; state_q <= S_IDLE;
				end
				default: state_q <= state_t'(state_q + 7'd1);
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) done |-> (state_q == S_IDLE))
		else $error("result shown outside the idle state");
	assert property (@(posedge clk) disable iff (!arst_n) done |=> !done)
		else $error("result shown longer than one cycle");
	assert property (@(posedge clk) disable iff (!arst_n) flip_done |-> !status)
		else $error("flip reported with error status");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !busy)
		else $error("busy while idle");
endmodule
`default_nettype wire

>>> design/hemef_ram.sv
`default_nettype none
module hemef_ram #(
	parameter int Width = 16,
	parameter int Depth = 4096
) (
	input  wire                      clk,
	input  wire                      we,
	input  wire  [$clog2(Depth)-1:0] addr,
	input  wire  [Width-1:0]         wdata,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule
`default_nettype wire

>>> dv/half_edge_mesh_edge_flip_tb.sv
`default_nettype none
// Stimulus runs in three phases. A small triangle strip mesh is loaded first,
// and every later access stays inside the loaded part of each table or goes to
// an entry written before, so that no access, not even one made inside a flip,
// can touch an entry that was never written. Then a short directed sequence
// covers the extremes and error cases. Then a long random mix of flips, reads,
// writes and bad items runs against the loaded mesh.
module half_edge_mesh_edge_flip_tb;
	import hemef_pkg::*;

	localparam int HalfEdgeN = 4096;
	localparam int VertexN = 4096;
	localparam int EdgeN = 4096;
	localparam int TriN = 50;
	localparam int HeUsed = 3 * TriN;
	localparam int VxUsed = TriN + 2;
	localparam int RandomItems = 1400;
	localparam int CycleLimit = 1500000;

	typedef struct {
		logic [15:0] rd;
		logic        fd;
		logic        st;
	} mesh_result_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	cmd_t        command;
	logic [2:0]  table_select;
	logic [11:0] entry_index;
	logic [15:0] write_value;
	logic        done;
	logic [15:0] read_value;
	logic        flip_done;
	logic        status;

	// The predicted contents of the five tables.
	logic [15:0] pred_hv[HalfEdgeN];
	logic [15:0] pred_ho[HalfEdgeN];
	logic [15:0] pred_eh[EdgeN];
	logic [15:0] pred_he[HalfEdgeN];
	logic [15:0] pred_vo[VertexN];

	mesh_result_t pending_results[$];
	int mismatch_count = 0;
	int cycle_count = 0;
	int mesh_edges = 0;
	int flips_done = 0;
	int flips_boundary = 0;
	int error_items = 0;
	int reads_done = 0;
	bit idle_on = 1'b1;

	half_edge_mesh_edge_flip u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.command(command),
		.table_select(table_select),
		.entry_index(entry_index),
		.write_value(write_value),
		.done(done),
		.read_value(read_value),
		.flip_done(flip_done),
		.status(status)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	// Half-edges come three to a triangle; these give the triangle neighbors.
	function automatic int tri_next(input int h);
		return h - h % 3 + (h % 3 + 1) % 3;
	endfunction

	function automatic int tri_prev(input int h);
		return h - h % 3 + (h % 3 + 2) % 3;
	endfunction

	function automatic bit tri_fits(input int h);
		return h < HalfEdgeN && (h - h % 3 + 2) < HalfEdgeN;
	endfunction

	function automatic bit opposite_ok(input int o);
		return o == int'(NIL) || o < HalfEdgeN;
	endfunction

	// Sets the edge of a half-edge and of its twin; a NIL twin is skipped.
	function automatic void link_edge(input int h, input int e);
		int o;
		o = pred_ho[h];
		pred_he[h] = e[15:0];
		if (o < HalfEdgeN)
			pred_he[o] = e[15:0];
	endfunction

	// Flips edge e in the predicted tables. The return value is the status;
	// performed is set only when the tables were rewritten.
	function automatic logic flip_edge(input int e, output logic performed);
		int ha, hb, pa, na, pb, nb, va, vb, vc, vd;
		int e_pa, e_na, e_pb, e_nb, o_pa, o_na, o_pb, o_nb;
		performed = 1'b0;
		if (e >= EdgeN)
			return 1'b1;
		ha = pred_eh[e];
		if (!tri_fits(ha))
			return 1'b1;
		hb = pred_ho[ha];
		// A boundary edge is left alone without an error.
		if (hb == int'(NIL))
			return 1'b0;
		if (!tri_fits(hb))
			return 1'b1;
		pa = tri_prev(ha);
		na = tri_next(ha);
		pb = tri_prev(hb);
		nb = tri_next(hb);
		va = pred_hv[ha];
		vb = pred_hv[hb];
		vc = pred_hv[pa];
		vd = pred_hv[pb];
		if (va >= VertexN || vb >= VertexN || vc >= VertexN || vd >= VertexN)
			return 1'b1;
		e_pa = pred_he[pa];
		e_na = pred_he[na];
		e_pb = pred_he[pb];
		e_nb = pred_he[nb];
		if (e_pa >= EdgeN || e_na >= EdgeN || e_pb >= EdgeN || e_nb >= EdgeN)
			return 1'b1;
		o_pa = pred_ho[pa];
		o_na = pred_ho[na];
		o_pb = pred_ho[pb];
		o_nb = pred_ho[nb];
		if (!opposite_ok(o_pa) || !opposite_ok(o_na) || !opposite_ok(o_pb) ||
				!opposite_ok(o_nb))
			return 1'b1;

		// The write order matters because some entries are shared.
		pred_hv[pa] = vb[15:0];
		pred_hv[ha] = vc[15:0];
		pred_hv[na] = vd[15:0];
		pred_hv[pb] = va[15:0];
		pred_hv[hb] = vd[15:0];
		pred_hv[nb] = vc[15:0];

		if (o_pa != int'(NIL)) pred_ho[o_pa] = nb[15:0];
		if (o_na != int'(NIL)) pred_ho[o_na] = pa[15:0];
		if (o_pb != int'(NIL)) pred_ho[o_pb] = na[15:0];
		if (o_nb != int'(NIL)) pred_ho[o_nb] = pb[15:0];

		pred_ho[pa] = o_na[15:0];
		pred_ho[na] = o_pb[15:0];
		pred_ho[pb] = o_nb[15:0];
		pred_ho[nb] = o_pa[15:0];

		pred_eh[e_pa] = pa[15:0];
		pred_eh[e_na] = na[15:0];
		pred_eh[e_pb] = pb[15:0];
		pred_eh[e_nb] = nb[15:0];

		link_edge(pa, e_pa);
		link_edge(na, e_na);
		link_edge(pb, e_pb);
		link_edge(nb, e_nb);

		if (pred_vo[va] == nb[15:0] || pred_vo[va] == ha[15:0]) pred_vo[va] = pb[15:0];
		if (pred_vo[vb] == na[15:0] || pred_vo[vb] == hb[15:0]) pred_vo[vb] = pa[15:0];
		if (pred_vo[vc] == pa[15:0]) pred_vo[vc] = nb[15:0];
		if (pred_vo[vd] == pb[15:0]) pred_vo[vd] = na[15:0];

		performed = 1'b1;
		return 1'b0;
	endfunction

	// An index inside the loaded part of the selected table.
	function automatic logic [11:0] used_index(input logic [2:0] sel);
		case (sel)
			TBL_EH: return 12'($urandom_range(mesh_edges - 1));
			TBL_VO: return 12'($urandom_range(VxUsed - 1));
			default: return 12'($urandom_range(HeUsed - 1));
		endcase
	endfunction

	// A value for the selected table. For HV, HO and EH it points into the loaded
	// part, is NIL or lies clearly out of range, so a later flip never reaches an
	// entry that was never written; for the other tables it is random.
	function automatic logic [15:0] safe_value(input logic [2:0] sel);
		int pick;
		pick = $urandom_range(3);
		case (sel)
			TBL_HV: begin
				if (pick == 0)
					return 16'($urandom_range(65535, 4096));
				return 16'($urandom_range(VxUsed - 1));
			end
			TBL_HO: begin
				if (pick == 0)
					return 16'($urandom_range(65535, 4096));
				if (pick == 1)
					return NIL;
				return 16'($urandom_range(HeUsed - 1));
			end
			TBL_EH: begin
				if (pick == 0)
					return 16'($urandom_range(65535, 4096));
				return 16'($urandom_range(HeUsed - 1));
			end
			default: return 16'($urandom);
		endcase
	endfunction

	// Applies one item to the predicted tables and returns its result.
	function automatic mesh_result_t mesh_step(input cmd_t c, input logic [2:0] sel,
			input logic [11:0] idx, input logic [15:0] val);
		mesh_result_t r;
		logic fd;
		r.rd = '0;
		r.fd = 1'b0;
		r.st = 1'b0;
		// All depths are 4096, so a 12-bit index is always in range.
		case (c)
			CMD_WRITE, CMD_READ: begin
				if (sel > TBL_VO) begin
					r.st = 1'b1;
				end else if (c == CMD_WRITE) begin
					case (sel)
						TBL_HV: pred_hv[idx] = val;
						TBL_HO: pred_ho[idx] = val;
						TBL_EH: pred_eh[idx] = val;
						TBL_HE: pred_he[idx] = val;
						default: pred_vo[idx] = val;
					endcase
				end else begin
					case (sel)
						TBL_HV: r.rd = pred_hv[idx];
						TBL_HO: r.rd = pred_ho[idx];
						TBL_EH: r.rd = pred_eh[idx];
						TBL_HE: r.rd = pred_he[idx];
						default: r.rd = pred_vo[idx];
					endcase
				end
			end
			CMD_FLIP: begin
				r.st = flip_edge(int'(idx), fd);
				r.fd = fd;
			end
			default: r.st = 1'b1;
		endcase
		return r;
	endfunction

	// Sends one item. It is called at a falling edge and returns at one; start
	// stays high so that a following item can go out with no gap.
	task automatic send_item(input cmd_t c, input logic [2:0] sel, input logic [11:0] idx,
			input logic [15:0] val);
		mesh_result_t r;
		if (idle_on && $urandom_range(99) < 9) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 5)) @(negedge clk);
		end
		start <= 1'b1;
		command <= c;
		table_select <= sel;
		entry_index <= idx;
		write_value <= val;
		do
			@(posedge clk);
		while (busy);
		r = mesh_step(c, sel, idx, val);
		if (c == CMD_FLIP && r.fd)
			flips_done++;
		else if (c == CMD_FLIP && !r.st)
			flips_boundary++;
		if (r.st)
			error_items++;
		if (c == CMD_READ && !r.st)
			reads_done++;
		pending_results = {pending_results, r};
		@(negedge clk);
	endtask

	// Each result is compared with the oldest expectation.
	always @(posedge clk) begin
		mesh_result_t exp_r;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected result: read_value %h flip_done %b status %b",
						read_value, flip_done, status);
			end else begin
				exp_r = pending_results.pop_front();
				if (read_value !== exp_r.rd || flip_done !== exp_r.fd || status !== exp_r.st) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("mismatch: expected %h/%b/%b, got %h/%b/%b (value/flip/status)",
							exp_r.rd, exp_r.fd, exp_r.st, read_value, flip_done, status);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CycleLimit) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("end of test: mismatches");
			$finish;
		end
	end

	// Loads a triangle strip. Triangle t uses vertices t, t+1 and t+2, with odd
	// triangles reversed so that all of them wind the same way. Neighboring
	// triangles share an edge; the outer edges have NIL opposites. Entries
	// outside the strip are not written here.
	task automatic test_load_mesh();
		logic [15:0] hv[HalfEdgeN];
		logic [15:0] ho[HalfEdgeN];
		logic [15:0] eh[EdgeN];
		logic [15:0] he[HalfEdgeN];
		logic [15:0] vo[VertexN];
		int dir_map[int];
		int u, v, t, h;
		for (t = 0; t < TriN; t++) begin
			hv[3 * t] = 16'((t % 2) ? t + 1 : t);
			hv[3 * t + 1] = 16'((t % 2) ? t : t + 1);
			hv[3 * t + 2] = 16'(t + 2);
		end
		for (h = 0; h < HeUsed; h++) begin
			u = hv[h];
			v = hv[tri_next(h)];
			dir_map[u * 8192 + v] = h;
			vo[u] = 16'(h);
		end
		for (h = 0; h < HeUsed; h++) begin
			u = hv[h];
			v = hv[tri_next(h)];
			ho[h] = dir_map.exists(v * 8192 + u) ? 16'(dir_map[v * 8192 + u]) : NIL;
		end
		for (h = 0; h < HeUsed; h++) begin
			if (ho[h] == NIL || h < int'(ho[h])) begin
				eh[mesh_edges] = 16'(h);
				he[h] = 16'(mesh_edges);
				if (ho[h] != NIL)
					he[ho[h]] = 16'(mesh_edges);
				mesh_edges++;
			end
		end
		for (h = 0; h < HeUsed; h++) begin
			send_item(CMD_WRITE, TBL_HV, 12'(h), hv[h]);
			send_item(CMD_WRITE, TBL_HO, 12'(h), ho[h]);
			send_item(CMD_WRITE, TBL_HE, 12'(h), he[h]);
		end
		for (h = 0; h < mesh_edges; h++)
			send_item(CMD_WRITE, TBL_EH, 12'(h), eh[h]);
		for (h = 0; h < VxUsed; h++)
			send_item(CMD_WRITE, TBL_VO, 12'(h), vo[h]);
	endtask

	// Extremes, every command, and error cases. Corrupted entries are put
	// back right after the flip that trips over them.
	task automatic test_directed();
		int e, ha;
		logic [15:0] saved;
		send_item(CMD_READ, TBL_HV, 12'd0, 16'd0);
		send_item(CMD_READ, TBL_HO, 12'(HeUsed - 1), 16'hFFFF);
		send_item(CMD_WRITE, TBL_VO, 12'hFFF, 16'hFFFF);
		send_item(CMD_READ, TBL_VO, 12'hFFF, 16'd0);
		send_item(CMD_WRITE, TBL_VO, 12'hFFF, 16'd0);
		send_item(CMD_READ, TBL_VO, 12'hFFF, 16'hFFFF);
		// Table selectors past the last table, and the unknown command.
		send_item(CMD_READ, 3'd5, 12'd1, 16'd0);
		send_item(CMD_WRITE, 3'd7, 12'hFFF, 16'hFFFF);
		send_item(CMD_BAD, TBL_HV, 12'd2, 16'd3);
		// Half-edge 0 lies on the outer side of the strip: a boundary edge.
		send_item(CMD_FLIP, TBL_HV, pred_he[0][11:0], 16'd0);
		// An edge whose half-edge triangle runs past the table end.
		send_item(CMD_WRITE, TBL_EH, 12'hFFF, 16'd4095);
		send_item(CMD_FLIP, TBL_HV, 12'hFFF, 16'd0);
		// Half-edge 3 is shared with the first triangle: an interior edge.
		e = pred_he[3];
		ha = pred_eh[e];
		saved = pred_hv[ha];
		send_item(CMD_WRITE, TBL_HV, 12'(ha), 16'd5000);
		send_item(CMD_FLIP, TBL_HV, 12'(e), 16'd0);
		send_item(CMD_WRITE, TBL_HV, 12'(ha), saved);
		saved = pred_he[tri_prev(ha)];
		send_item(CMD_WRITE, TBL_HE, 12'(tri_prev(ha)), 16'd5000);
		send_item(CMD_FLIP, TBL_HV, 12'(e), 16'd0);
		send_item(CMD_WRITE, TBL_HE, 12'(tri_prev(ha)), saved);
		saved = pred_ho[tri_next(ha)];
		send_item(CMD_WRITE, TBL_HO, 12'(tri_next(ha)), 16'd5000);
		send_item(CMD_FLIP, TBL_HV, 12'(e), 16'd0);
		send_item(CMD_WRITE, TBL_HO, 12'(tri_next(ha)), saved);
		// A good flip, then flipping the same edge back.
		send_item(CMD_FLIP, TBL_HV, 12'(e), 16'd0);
		send_item(CMD_FLIP, TBL_HV, 12'(e), 16'd0);
		send_item(CMD_READ, TBL_EH, 12'(e), 16'd0);
	endtask

	// Mostly flips of real edges and reads, with some writes that bend the mesh
	// and some bad items. Writes to HV, HO and EH keep their values inside the
	// loaded part or clearly out of range. Idling is off for a stretch in the middle.
	task automatic test_random();
		int n, pick;
		logic [2:0] sel;
		for (n = 0; n < RandomItems; n++) begin
			idle_on = !(n >= 500 && n < 900);
			pick = $urandom_range(99);
			sel = 3'($urandom_range(4));
			if (pick < 45)
				send_item(CMD_FLIP, 3'($urandom), 12'($urandom_range(mesh_edges - 1)),
					16'($urandom));
			else if (pick < 50)
				send_item(CMD_FLIP, 3'($urandom), 12'hFFF, 16'($urandom));
			else if (pick < 85)
				send_item(CMD_READ, sel, used_index(sel), 16'($urandom));
			else if (pick < 93)
				send_item(CMD_WRITE, sel, used_index(sel), safe_value(sel));
			else if (pick < 97)
				send_item(cmd_t'($urandom_range(1)), 3'($urandom_range(5, 7)),
					12'($urandom), 16'($urandom));
			else
				send_item(CMD_BAD, 3'($urandom), 12'($urandom), 16'($urandom));
		end
		idle_on = 1'b1;
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		command = CMD_READ;
		table_select = '0;
		entry_index = '0;
		write_value = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_load_mesh();
		test_directed();
		test_random();

		start <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);

		$display("covered %0d edges: %0d flips done, %0d boundary flips, %0d reads,",
			mesh_edges, flips_done, flips_boundary, reads_done);
		$display("%0d items with error status, %0d mismatches", error_items, mismatch_count);
		if (mismatch_count == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end
endmodule
`default_nettype wire
